>>> hdl/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg: shared types and constants of the Harris corner response block
// Field widths, register reset values, controller states, command and status
// bundles, and the table of Sobel taps.
// ----------------------------------------------------------------------------
package hcr_pkg;

    localparam int PIX_W       = 8;
    localparam int RESP_W      = 48;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 12;
    localparam int K_W         = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int GRAD_W      = 11;
    localparam int TAP_PROD_W  = 12;
    localparam int SQ_W        = 22;
    localparam int SUM_W       = 24;
    localparam int KPROD_W     = RESP_W + K_W;
    localparam int QUEUE_DEPTH = 16;
    localparam int Q_IDX_W     = 4;
    localparam int Q_CNT_W     = 5;
    localparam int MAX_BEATS   = 4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [K_W-1:0]      K_RESET      = 16'd2621;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_K      = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_LOADPT,
        S_RD,
        S_PROD,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_PUSH,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ROW_UP,
        ROW_MID,
        ROW_DOWN
    } t_rsel;

    typedef enum logic [1:0] {
        COL_LEFT,
        COL_CENTER,
        COL_RIGHT
    } t_csel;

    typedef struct packed {
        t_rsel             rsel;
        t_csel             csel;
        logic signed [2:0] cx;
        logic signed [2:0] cy;
    } t_tap;

    typedef struct packed {
        logic       accept;
        logic       load_pair;
        logic       load_pt;
        logic       rd_en;
        logic [2:0] rd_k;
        logic       acc_clear;
        logic       acc_en;
        logic [2:0] acc_k;
        logic       prod;
        logic       m1;
        logic       m2;
        logic       m3;
        logic       m4;
        logic       push;
        logic       pop;
        logic [1:0] ri;
        logic [1:0] ci;
        logic [1:0] pt;
    } t_cmd;

    typedef struct packed {
        logic [2:0] row_flag;
        logic [2:0] col_flag;
        logic       q_empty;
        logic       q_one;
    } t_status;

    // The eight neighbors of a Sobel point, with their weights in gx and gy.
    function automatic t_tap sobel_tap(input logic [2:0] k);
        t_tap t;
        case (k)
            3'd0:    t = '{ROW_UP,   COL_LEFT,   -3'sd1, -3'sd1};
            3'd1:    t = '{ROW_UP,   COL_CENTER,  3'sd0, -3'sd2};
            3'd2:    t = '{ROW_UP,   COL_RIGHT,   3'sd1, -3'sd1};
            3'd3:    t = '{ROW_MID,  COL_LEFT,   -3'sd2,  3'sd0};
            3'd4:    t = '{ROW_MID,  COL_RIGHT,   3'sd2,  3'sd0};
            3'd5:    t = '{ROW_DOWN, COL_LEFT,   -3'sd1,  3'sd1};
            3'd6:    t = '{ROW_DOWN, COL_CENTER,  3'sd0,  3'sd2};
            3'd7:    t = '{ROW_DOWN, COL_RIGHT,   3'sd1,  3'sd1};
            default: t = '{ROW_MID,  COL_CENTER,  3'sd0,  3'sd0};
        endcase
        return t;
    endfunction

endpackage

>>> hdl/hcr_ctrl.sv
// ----------------------------------------------------------------------------
// hcr_ctrl: sequencer of the Harris corner response block
// Walks the candidate window positions of one pixel, steps the datapath
// through gradient reads, products and the response, then drains results.
// ----------------------------------------------------------------------------
module hcr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  hcr_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic             o_last_in_run,
    output hcr_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] LAST_IDX  = 2'd2;
    localparam logic [1:0] LAST_PT   = 2'd3;
    localparam logic [3:0] LAST_K    = 4'd8;
    localparam logic [1:0] LAST_BEAT = 2'(hcr_pkg::MAX_BEATS - 1);

    hcr_pkg::t_state r_state, n_state;
    logic [1:0] r_ri, n_ri;
    logic [1:0] r_ci, n_ci;
    logic [1:0] r_pt, n_pt;
    logic [3:0] r_k, n_k;
    logic [1:0] r_nbeat, n_nbeat;

    logic            pair_ok;
    logic            last_beat;
    hcr_pkg::t_state adv_state;
    logic [1:0]      adv_ri;
    logic [1:0]      adv_ci;

    assign pair_ok   = i_status.row_flag[r_ri] && i_status.col_flag[r_ci];
    assign last_beat = (r_nbeat == LAST_BEAT) || i_status.q_one;

    always_comb begin
        adv_state = hcr_pkg::S_PICK;
        adv_ri    = r_ri;
        adv_ci    = r_ci + 2'd1;
        if (r_ri == LAST_IDX && r_ci == LAST_IDX) begin
            adv_state = hcr_pkg::S_EMIT;
            adv_ci    = r_ci;
        end else if (r_ci == LAST_IDX) begin
            adv_ri = r_ri + 2'd1;
            adv_ci = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcr_pkg::S_IDLE;
            r_ri    <= '0;
            r_ci    <= '0;
            r_pt    <= '0;
            r_k     <= '0;
            r_nbeat <= '0;
        end else begin
            r_state <= n_state;
            r_ri    <= n_ri;
            r_ci    <= n_ci;
            r_pt    <= n_pt;
            r_k     <= n_k;
            r_nbeat <= n_nbeat;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ri    = r_ri;
        n_ci    = r_ci;
        n_pt    = r_pt;
        n_k     = r_k;
        n_nbeat = r_nbeat;
        case (r_state)
            hcr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = hcr_pkg::S_PICK;
                    n_ri    = '0;
                    n_ci    = '0;
                end
            end
            hcr_pkg::S_PICK: begin
                if (pair_ok) begin
                    n_state = hcr_pkg::S_LOADPT;
                    n_pt    = '0;
                end else begin
                    n_state = adv_state;
                    n_ri    = adv_ri;
                    n_ci    = adv_ci;
                    n_nbeat = '0;
                end
            end
            hcr_pkg::S_LOADPT: begin
                n_state = hcr_pkg::S_RD;
                n_k     = '0;
            end
            hcr_pkg::S_RD: begin
                if (r_k == LAST_K) begin
                    n_state = hcr_pkg::S_PROD;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            hcr_pkg::S_PROD: begin
                if (r_pt == LAST_PT) begin
                    n_state = hcr_pkg::S_M1;
                end else begin
                    n_state = hcr_pkg::S_LOADPT;
                    n_pt    = r_pt + 2'd1;
                end
            end
            hcr_pkg::S_M1: n_state = hcr_pkg::S_M2;
            hcr_pkg::S_M2: n_state = hcr_pkg::S_M3;
            hcr_pkg::S_M3: n_state = hcr_pkg::S_M4;
            hcr_pkg::S_M4: n_state = hcr_pkg::S_PUSH;
            hcr_pkg::S_PUSH: begin
                n_state = adv_state;
                n_ri    = adv_ri;
                n_ci    = adv_ci;
                n_nbeat = '0;
            end
            hcr_pkg::S_EMIT: begin
                if (i_status.q_empty) begin
                    n_state = hcr_pkg::S_IDLE;
                end else if (i_out_ready) begin
                    if (last_beat) begin
                        n_state = hcr_pkg::S_IDLE;
                    end else begin
                        n_nbeat = r_nbeat + 2'd1;
                    end
                end
            end
            default: n_state = hcr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == hcr_pkg::S_IDLE);
        o_out_valid     = (r_state == hcr_pkg::S_EMIT) && !i_status.q_empty;
        o_last_in_run   = last_beat;
        o_cmd           = '0;
        o_cmd.ri        = r_ri;
        o_cmd.ci        = r_ci;
        o_cmd.pt        = r_pt;
        o_cmd.rd_k      = r_k[2:0];
        o_cmd.acc_k     = 3'(r_k - 4'd1);
        case (r_state)
            hcr_pkg::S_IDLE:   o_cmd.accept = i_in_valid;
            hcr_pkg::S_PICK:   o_cmd.load_pair = pair_ok;
            hcr_pkg::S_LOADPT: o_cmd.load_pt = 1'b1;
            hcr_pkg::S_RD: begin
                o_cmd.rd_en     = (r_k != LAST_K);
                o_cmd.acc_clear = (r_k == 4'd0);
                o_cmd.acc_en    = (r_k != 4'd0);
            end
            hcr_pkg::S_PROD:   o_cmd.prod = 1'b1;
            hcr_pkg::S_M1:     o_cmd.m1 = 1'b1;
            hcr_pkg::S_M2:     o_cmd.m2 = 1'b1;
            hcr_pkg::S_M3:     o_cmd.m3 = 1'b1;
            hcr_pkg::S_M4:     o_cmd.m4 = 1'b1;
            hcr_pkg::S_PUSH:   o_cmd.push = 1'b1;
            hcr_pkg::S_EMIT:   o_cmd.pop = !i_status.q_empty && i_out_ready;
            default:           o_cmd.accept = 1'b0;
        endcase
    end

endmodule

>>> hdl/hcr_datapath.sv
// ----------------------------------------------------------------------------
// hcr_datapath: storage and arithmetic of the Harris corner response block
// Holds the configuration registers, raster position, four-line pixel store,
// gradient accumulators, structure-tensor sums, the response pipeline and
// the result queue.
// ----------------------------------------------------------------------------
module hcr_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [hcr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hcr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [hcr_pkg::PIX_W-1:0]            i_pixel,
    input  hcr_pkg::t_cmd                        i_cmd,
    output hcr_pkg::t_status                     o_status,
    output logic signed [hcr_pkg::RESP_W-1:0]    o_response,
    output logic [hcr_pkg::ROW_W-1:0]            o_row,
    output logic [hcr_pkg::COL_W-1:0]            o_col
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EW    = CW + 1;
    localparam int WW    = (EW > hcr_pkg::WIDTH_W) ? EW : hcr_pkg::WIDTH_W;
    localparam int DEPTH = 4 * (2 ** CW);
    localparam int RW    = hcr_pkg::ROW_W;

    logic [hcr_pkg::WIDTH_W-1:0]  r_image_width;
    logic [hcr_pkg::HEIGHT_W-1:0] r_image_height;
    logic [hcr_pkg::K_W-1:0]      r_harris_k;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic [2:0]    r_row_flag;
    logic [2:0]    r_col_flag;

    logic [RW-1:0] r_r;
    logic [CW-1:0] r_c;
    logic [RW-1:0] r_py;
    logic [CW-1:0] r_px;

    logic [hcr_pkg::PIX_W-1:0] mem [DEPTH];
    logic [hcr_pkg::PIX_W-1:0] r_rd_data;

    logic signed [hcr_pkg::GRAD_W-1:0] r_gx;
    logic signed [hcr_pkg::GRAD_W-1:0] r_gy;
    logic signed [hcr_pkg::SUM_W-1:0]  r_sa;
    logic signed [hcr_pkg::SUM_W-1:0]  r_sb;
    logic signed [hcr_pkg::SUM_W-1:0]  r_sc;
    logic signed [hcr_pkg::SUM_W-1:0]  r_s;
    logic signed [hcr_pkg::RESP_W-1:0] r_p1;
    logic signed [hcr_pkg::RESP_W-1:0] r_p2;
    logic [hcr_pkg::RESP_W-1:0]        r_ss;
    logic [hcr_pkg::RESP_W-1:0]        r_term;

    logic signed [hcr_pkg::RESP_W-1:0] q_resp [hcr_pkg::QUEUE_DEPTH];
    logic [hcr_pkg::ROW_W-1:0]         q_row  [hcr_pkg::QUEUE_DEPTH];
    logic [hcr_pkg::COL_W-1:0]         q_col  [hcr_pkg::QUEUE_DEPTH];
    logic [hcr_pkg::Q_IDX_W-1:0]       r_head;
    logic [hcr_pkg::Q_CNT_W-1:0]       r_count;
    logic [hcr_pkg::Q_IDX_W-1:0]       tail;

    logic [WW-1:0] w_raw;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] w_m1;
    logic [RW-1:0] h_eff;
    logic [RW-1:0] h_m1;
    logic [EW-1:0] col_ext;
    logic [EW-1:0] col_inc;
    logic [RW-1:0] row_inc;
    logic [2:0]    row_flag;
    logic [2:0]    col_flag;

    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [RW-1:0] py_up;
    logic [RW-1:0] py_down;
    logic [CW-1:0] px_left;
    logic [CW-1:0] px_right;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic [RW+CW-1:0] rd_addr_full;

    hcr_pkg::t_tap rd_tap;
    hcr_pkg::t_tap acc_tap;
    logic signed [hcr_pkg::PIX_W:0]        pix_s;
    logic signed [hcr_pkg::TAP_PROD_W-1:0] gx_t;
    logic signed [hcr_pkg::TAP_PROD_W-1:0] gy_t;
    logic signed [hcr_pkg::SQ_W-1:0]       sq_xx;
    logic signed [hcr_pkg::SQ_W-1:0]       sq_xy;
    logic signed [hcr_pkg::SQ_W-1:0]       sq_yy;
    logic [hcr_pkg::KPROD_W-1:0]           kprod;
    logic signed [hcr_pkg::RESP_W-1:0]     resp;

    // Effective frame size, clamped to the supported range.
    always_comb begin
        w_raw = WW'(r_image_width);
        if (w_raw < WW'(2)) begin
            w_eff = EW'(2);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(w_raw);
        end
        if (r_image_height < 12'd2) begin
            h_eff = 12'd2;
        end else begin
            h_eff = r_image_height;
        end
        w_m1 = w_eff - EW'(1);
        h_m1 = h_eff - 12'd1;
    end

    // Window positions completed by the pixel at the current position:
    // the first one, the one before the pixel, and the last one of the axis.
    always_comb begin
        col_ext     = EW'(r_col);
        col_inc     = col_ext + EW'(1);
        row_inc     = r_row + 12'd1;
        row_flag[0] = (r_row == ((h_m1 < 12'd2) ? h_m1 : 12'd2));
        row_flag[1] = (r_row >= 12'd2) && (r_row <= h_m1);
        row_flag[2] = (r_row >= 12'd1) && (r_row == h_m1);
        col_flag[0] = (col_ext == ((w_m1 < EW'(2)) ? w_m1 : EW'(2)));
        col_flag[1] = (col_ext >= EW'(2)) && (col_ext <= w_m1);
        col_flag[2] = (col_ext >= EW'(1)) && (col_ext == w_m1);
    end

    always_comb begin
        case (i_cmd.ri)
            2'd0:    sel_row = '0;
            2'd1:    sel_row = r_cur_row - 12'd1;
            default: sel_row = r_cur_row;
        endcase
        case (i_cmd.ci)
            2'd0:    sel_col = '0;
            2'd1:    sel_col = r_cur_col - CW'(1);
            default: sel_col = r_cur_col;
        endcase
    end

    // Neighbor coordinates with reflect-101 borders.
    always_comb begin
        py_up    = (r_py == '0) ? 12'd1 : r_py - 12'd1;
        py_down  = (r_py + 12'd1 == h_eff) ? h_eff - 12'd2 : r_py + 12'd1;
        px_left  = (r_px == '0) ? CW'(1) : r_px - CW'(1);
        px_right = (EW'(r_px) + EW'(1) == w_eff) ? CW'(w_eff - EW'(2)) : r_px + CW'(1);
        rd_tap   = hcr_pkg::sobel_tap(i_cmd.rd_k);
        case (rd_tap.rsel)
            hcr_pkg::ROW_UP:   rd_row = py_up;
            hcr_pkg::ROW_DOWN: rd_row = py_down;
            default:           rd_row = r_py;
        endcase
        case (rd_tap.csel)
            hcr_pkg::COL_LEFT:  rd_col = px_left;
            hcr_pkg::COL_RIGHT: rd_col = px_right;
            default:            rd_col = r_px;
        endcase
        rd_addr_full = {rd_row, rd_col};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[{r_row[1:0], r_col}] <= i_pixel;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr_full[CW+1:0]];
        end
    end

    always_comb begin
        acc_tap = hcr_pkg::sobel_tap(i_cmd.acc_k);
        pix_s   = $signed({1'b0, r_rd_data});
        gx_t    = acc_tap.cx * pix_s;
        gy_t    = acc_tap.cy * pix_s;
        sq_xx   = r_gx * r_gx;
        sq_xy   = r_gx * r_gy;
        sq_yy   = r_gy * r_gy;
        kprod   = r_ss * r_harris_k;
        resp    = r_p1 - r_p2 - $signed(r_term);
        tail    = r_head + r_count[hcr_pkg::Q_IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= hcr_pkg::WIDTH_RESET;
            r_image_height <= hcr_pkg::HEIGHT_RESET;
            r_harris_k     <= hcr_pkg::K_RESET;
            r_row          <= '0;
            r_col          <= '0;
            r_head         <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hcr_pkg::CFG_WIDTH:  r_image_width <= i_cfg_data[hcr_pkg::WIDTH_W-1:0];
                    hcr_pkg::CFG_HEIGHT: r_image_height <= i_cfg_data[hcr_pkg::HEIGHT_W-1:0];
                    hcr_pkg::CFG_K:      r_harris_k <= i_cfg_data;
                    default:             r_harris_k <= r_harris_k;
                endcase
            end
            if (i_cmd.accept) begin
                if (col_inc >= w_eff) begin
                    r_col <= '0;
                    r_row <= (row_inc >= h_eff) ? '0 : row_inc;
                end else begin
                    r_col <= CW'(col_inc);
                end
            end
            if (i_cmd.push && r_count != hcr_pkg::Q_CNT_W'(hcr_pkg::QUEUE_DEPTH)) begin
                r_count <= r_count + 5'd1;
            end else if (i_cmd.pop) begin
                r_head  <= r_head + 4'd1;
                r_count <= r_count - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_row  <= r_row;
            r_cur_col  <= r_col;
            r_row_flag <= row_flag;
            r_col_flag <= col_flag;
        end
        if (i_cmd.load_pair) begin
            r_r  <= sel_row;
            r_c  <= sel_col;
            r_sa <= '0;
            r_sb <= '0;
            r_sc <= '0;
        end
        if (i_cmd.load_pt) begin
            r_py <= i_cmd.pt[1] ? r_r : ((r_r == '0) ? 12'd1 : r_r - 12'd1);
            r_px <= i_cmd.pt[0] ? r_c : ((r_c == '0) ? CW'(1) : r_c - CW'(1));
        end
        if (i_cmd.acc_clear) begin
            r_gx <= '0;
            r_gy <= '0;
        end else if (i_cmd.acc_en) begin
            r_gx <= r_gx + hcr_pkg::GRAD_W'(gx_t);
            r_gy <= r_gy + hcr_pkg::GRAD_W'(gy_t);
        end
        if (i_cmd.prod) begin
            r_sa <= r_sa + hcr_pkg::SUM_W'(sq_xx);
            r_sb <= r_sb + hcr_pkg::SUM_W'(sq_xy);
            r_sc <= r_sc + hcr_pkg::SUM_W'(sq_yy);
        end
        if (i_cmd.m1) begin
            r_p1 <= r_sa * r_sc;
            r_s  <= r_sa + r_sc;
        end
        if (i_cmd.m2) begin
            r_p2 <= r_sb * r_sb;
        end
        if (i_cmd.m3) begin
            r_ss <= r_s * r_s;
        end
        if (i_cmd.m4) begin
            r_term <= kprod[hcr_pkg::KPROD_W-1:hcr_pkg::K_W];
        end
        if (i_cmd.push && r_count != hcr_pkg::Q_CNT_W'(hcr_pkg::QUEUE_DEPTH)) begin
            q_resp[tail] <= resp;
            q_row[tail]  <= r_r;
            q_col[tail]  <= hcr_pkg::COL_W'(r_c);
        end
    end

    always_comb begin
        o_status.row_flag = r_row_flag;
        o_status.col_flag = r_col_flag;
        o_status.q_empty  = (r_count == '0);
        o_status.q_one    = (r_count == 5'd1);
        o_response        = q_resp[r_head];
        o_row             = q_row[r_head];
        o_col             = q_col[r_head];
    end

endmodule

>>> hdl/harris_corner_response.sv
// ----------------------------------------------------------------------------
// harris_corner_response: Harris corner response over a gray pixel stream
// Sobel gradients, 2x2 structure-tensor sums with reflect-101 borders, and
// a*c - b*b - k*(a+c)^2; k is a 16-bit fraction, its product truncated.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the input channel (i_in_valid, o_in_ready,
// i_pixel). Each pixel beat may complete zero to nine responses; these are
// queued and up to four leave on the output channel (o_out_valid,
// i_out_ready) after the pixel, the final one with o_last_in_run set.
// Leftover results leave first after the next pixel.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) writes width, height and k; it is always ready and is meant
// to be used only while the block is idle.
// One item is processed at a time. Each response that a pixel completes
// takes four Sobel points of eight reads each from the line store, whose
// one read port sets the pace, then four multiply steps; the queued results
// then leave one per output beat.
// o_in_ready stays low until the pixel's output beats are taken; a
// stalled receiver holds the block in its drain state. Reset restores the
// default frame size and k, clears the position and empties the queue.
// ----------------------------------------------------------------------------
module harris_corner_response #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hcr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hcr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [hcr_pkg::PIX_W-1:0]            i_pixel,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [hcr_pkg::RESP_W-1:0]    o_response,
    output logic [hcr_pkg::ROW_W-1:0]            o_row,
    output logic [hcr_pkg::COL_W-1:0]            o_col,
    output logic                                 o_last_in_run
);

    hcr_pkg::t_cmd    cmd;
    hcr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    hcr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (status),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_last_in_run (o_last_in_run),
        .o_cmd         (cmd)
    );

    hcr_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_pixel),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_response  (o_response),
        .o_row       (o_row),
        .o_col       (o_col)
    );

endmodule

>>> hdl/hcr_checker.sv
// ----------------------------------------------------------------------------
// hcr_checker: port-level checks of the Harris corner response block
// Watches the handshakes and the one-item-at-a-time sequencing.
// ----------------------------------------------------------------------------
module hcr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [hcr_pkg::RESP_W-1:0]    o_response,
    input logic [hcr_pkg::ROW_W-1:0]            o_row,
    input logic [hcr_pkg::COL_W-1:0]            o_col,
    input logic                                 o_last_in_run
);

    // A stalled result beat stays offered with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_response)
            && $stable(o_row) && $stable(o_col) && $stable(o_last_in_run))
        else $error("result beat changed while stalled");

    // Results drain only while no pixel is being taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while results are offered");

    // The last beat of a pixel ends the drain.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_in_run |=> !o_out_valid)
        else $error("result offered after the last beat of a pixel");

    // A pixel beat starts processing, so the input closes at once.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still ready after a pixel beat");

endmodule

bind harris_corner_response hcr_checker u_hcr_checker (.*);
